// ----- rtl/core/mau_pkg.sv -----
// Shared constants and types of the modular arithmetic unit.
package mau_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int EXP_WIDTH_DEF   = 63;

    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_NEG = 3'd2,
        CMD_MUL = 3'd3,
        CMD_DIV = 3'd4,
        CMD_POW = 3'd5,
        CMD_INV = 3'd6,
        CMD_EQU = 3'd7
    } cmd_t;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_RED_A    = 9'b000000010,
        S_RED_B    = 9'b000000100,
        S_DISPATCH = 9'b000001000,
        S_POW_LOOP = 9'b000010000,
        S_POW_MUL  = 9'b000100000,
        S_POW_SQR  = 9'b001000000,
        S_MUL      = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

endpackage

// ----- rtl/core/mau_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, most significant first.
module mau_mulmod
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] x,
    input  logic [VALUE_WIDTH-1:0] y,
    input  logic [VALUE_WIDTH-1:0] m,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] product
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    logic [VALUE_WIDTH:0]   dbl;
    logic [VALUE_WIDTH:0]   dbl_red;
    logic [VALUE_WIDTH:0]   sum;
    logic [VALUE_WIDTH:0]   sum_red;
    logic [VALUE_WIDTH:0]   m_ext;

    assign m_ext   = {1'b0, m};
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    assign sum     = dbl_red + (x_reg[VALUE_WIDTH-1] ? {1'b0, y} : '0);
    assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH);
            x_next    = x;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[VALUE_WIDTH-1:0];
            x_next   = {x_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/core/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit: item sequencer, operand registers and output register.
// One item is worked on at a time; every multiplication, and the reduction of each raw operand,
// runs through a single bit-serial modular multiplier. Add, subtract, negate and equality are
// computed directly from the reduced operands; multiply runs the multiplier once more. Power
// takes up to 2 * EXP_WIDTH + 2 multiplications; inverse and divide raise to modulus minus two
// and so take up to 2 * VALUE_WIDTH + 3 multiplications. A modulus below two skips the
// multiplier and answers zero, or one for equality. A new beat is taken while an earlier result
// still waits at the output.
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int EXP_WIDTH   = EXP_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [VALUE_WIDTH-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             command,
    input  logic [VALUE_WIDTH-1:0] operand_a,
    input  logic [VALUE_WIDTH-1:0] operand_b,
    input  logic [EXP_WIDTH-1:0]   exponent,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int XW = (EXP_WIDTH > VALUE_WIDTH) ? EXP_WIDTH : VALUE_WIDTH;

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   mm_start_reg, mm_start_next;
    logic [VALUE_WIDTH-1:0] modulus_reg, modulus_next;

    cmd_t                   cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [XW-1:0]          exp_reg, exp_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] base_reg, base_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [VALUE_WIDTH-1:0] mm_x_reg, mm_x_next;
    logic [VALUE_WIDTH-1:0] mm_y_reg, mm_y_next;

    logic                   mm_done;
    logic [VALUE_WIDTH-1:0] mm_product;

    logic [VALUE_WIDTH-1:0] one_val;
    logic [VALUE_WIDTH:0]   m_ext;
    logic [VALUE_WIDTH:0]   sum_ab;
    logic [VALUE_WIDTH-1:0] add_res;
    logic [VALUE_WIDTH-1:0] sub_res;
    logic [VALUE_WIDTH-1:0] neg_res;
    logic [VALUE_WIDTH-1:0] m_minus_two;
    logic                   out_free;

    assign one_val     = VALUE_WIDTH'(1);
    assign m_ext       = {1'b0, modulus_reg};
    assign sum_ab      = {1'b0, a_reg} + {1'b0, b_reg};
    assign add_res     = (sum_ab >= m_ext) ? VALUE_WIDTH'(sum_ab - m_ext)
                                           : VALUE_WIDTH'(sum_ab);
    assign sub_res     = (a_reg >= b_reg) ? a_reg - b_reg
                       : VALUE_WIDTH'({1'b0, a_reg} + m_ext - {1'b0, b_reg});
    assign neg_res     = (a_reg != '0) ? modulus_reg - a_reg : '0;
    assign m_minus_two = modulus_reg - VALUE_WIDTH'(2);
    assign out_free    = !out_valid_reg || !out_stall;

    mau_mulmod #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .x       (mm_x_reg),
        .y       (mm_y_reg),
        .m       (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        mm_start_next  = 1'b0;
        modulus_next   = modulus_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        mm_x_next      = mm_x_reg;
        mm_y_next      = mm_y_reg;

        if (cfg_valid)
        begin
            modulus_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd_t'(command);
                    a_next   = operand_a;
                    b_next   = operand_b;
                    exp_next = XW'(exponent);
                    if (modulus_reg < VALUE_WIDTH'(2))
                    begin
                        acc_next   = (cmd_t'(command) == CMD_EQU) ? one_val : '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mm_x_next     = operand_a;
                        mm_y_next     = one_val;
                        mm_start_next = 1'b1;
                        state_next    = S_RED_A;
                    end
                end
            end
            S_RED_A:
            begin
                if (mm_done)
                begin
                    a_next        = mm_product;
                    mm_x_next     = b_reg;
                    mm_y_next     = one_val;
                    mm_start_next = 1'b1;
                    state_next    = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (mm_done)
                begin
                    b_next     = mm_product;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_ADD: acc_next = add_res;
                    CMD_SUB: acc_next = sub_res;
                    CMD_NEG: acc_next = neg_res;
                    CMD_EQU: acc_next = (a_reg == b_reg) ? one_val : '0;
                    CMD_MUL:
                    begin
                        mm_x_next     = a_reg;
                        mm_y_next     = b_reg;
                        mm_start_next = 1'b1;
                        state_next    = S_MUL;
                    end
                    CMD_POW:
                    begin
                        base_next  = a_reg;
                        acc_next   = one_val;
                        state_next = S_POW_LOOP;
                    end
                    CMD_INV:
                    begin
                        if (a_reg == '0)
                        begin
                            acc_next = '0;
                        end
                        else
                        begin
                            base_next  = a_reg;
                            exp_next   = XW'(m_minus_two);
                            acc_next   = one_val;
                            state_next = S_POW_LOOP;
                        end
                    end
                    CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            acc_next = '0;
                        end
                        else
                        begin
                            base_next  = b_reg;
                            exp_next   = XW'(m_minus_two);
                            acc_next   = one_val;
                            state_next = S_POW_LOOP;
                        end
                    end
                    default: acc_next = '0;
                endcase
            end
            S_POW_LOOP:
            begin
                if (exp_reg == '0)
                begin
                    if (cmd_reg == CMD_DIV)
                    begin
                        mm_x_next     = a_reg;
                        mm_y_next     = acc_reg;
                        mm_start_next = 1'b1;
                        state_next    = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (exp_reg[0])
                begin
                    mm_x_next     = acc_reg;
                    mm_y_next     = base_reg;
                    mm_start_next = 1'b1;
                    state_next    = S_POW_MUL;
                end
                else
                begin
                    mm_x_next     = base_reg;
                    mm_y_next     = base_reg;
                    mm_start_next = 1'b1;
                    state_next    = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (exp_reg[XW-1:1] == '0)
                    begin
                        exp_next   = '0;
                        state_next = S_POW_LOOP;
                    end
                    else
                    begin
                        mm_x_next     = base_reg;
                        mm_y_next     = base_reg;
                        mm_start_next = 1'b1;
                        state_next    = S_POW_SQR;
                    end
                end
            end
            S_POW_SQR:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    exp_next   = exp_reg >> 1;
                    state_next = S_POW_LOOP;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_product;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mm_start_reg  <= 1'b0;
            modulus_reg   <= VALUE_WIDTH'(MODULUS_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mm_start_reg  <= mm_start_next;
            modulus_reg   <= modulus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        mm_x_reg <= mm_x_next;
        mm_y_reg <= mm_y_next;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the modular arithmetic unit: directed table, random beats, predictor.
module testbench
    import mau_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int EW          = EXP_WIDTH_DEF;
    localparam int PLAN_ROWS   = 29;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 19;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [VW-1:0] PRIME_MAX = 32'd4294967291;

    typedef struct packed {
        logic          is_cfg;
        cmd_t          cmd;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [EW-1:0] e;
        logic          typed;
        logic [VW-1:0] want;
    } plan_row_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [VW-1:0] cfg_data;
    logic          in_valid;
    logic          in_stall;
    logic [2:0]    command;
    logic [VW-1:0] operand_a;
    logic [VW-1:0] operand_b;
    logic [EW-1:0] exponent;
    logic          out_valid;
    logic          out_stall;
    logic [VW-1:0] result;

    logic [VW-1:0] awaited_results[$];
    logic [VW-1:0] modulus_now;
    plan_row_t     plan [PLAN_ROWS];
    int            mismatches;
    int            beats_out;
    int            cycles;
    bit            gaps_on;

    modular_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        if (m < 2)
            return 64'd0;
        return (x * y) % m;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [EW-1:0] e,
                                            logic [63:0] m);
        logic [63:0]   acc;
        logic [63:0]   p;
        logic [EW-1:0] rest;
        acc  = (m < 2) ? 64'd0 : 64'd1 % m;
        p    = base;
        rest = e;
        while (rest != 0)
        begin
            if (rest[0])
                acc = mul_mod(acc, p, m);
            p    = mul_mod(p, p, m);
            rest = rest >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] inverse_mod(logic [63:0] a, logic [63:0] m);
        logic [63:0] e;
        if (m < 2 || a == 0)
            return 64'd0;
        e = m - 2;
        return pow_mod(a, e[EW-1:0], m);
    endfunction

    function automatic logic [VW-1:0] predict_result(cmd_t c, logic [VW-1:0] ra,
                                                     logic [VW-1:0] rb, logic [EW-1:0] e,
                                                     logic [VW-1:0] modv);
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        m = {32'd0, modv};
        a = (m < 2) ? 64'd0 : {32'd0, ra} % m;
        b = (m < 2) ? 64'd0 : {32'd0, rb} % m;
        case (c)
            CMD_ADD:
            begin
                r = a + b;
                if (m >= 2 && r >= m)
                    r = r - m;
            end
            CMD_SUB: r = (a >= b) ? a - b : a + m - b;
            CMD_NEG: r = (a != 0) ? m - a : 64'd0;
            CMD_MUL: r = mul_mod(a, b, m);
            CMD_DIV: r = mul_mod(a, inverse_mod(b, m), m);
            CMD_POW: r = pow_mod(a, e, m);
            CMD_INV: r = inverse_mod(a, m);
            default: r = (a == b) ? 64'd1 : 64'd0;
        endcase
        return r[VW-1:0];
    endfunction

    task automatic report(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endtask

    task automatic offer(cmd_t c, logic [VW-1:0] a, logic [VW-1:0] b, logic [EW-1:0] e,
                         logic [VW-1:0] want);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= c;
        operand_a <= a;
        operand_b <= b;
        exponent  <= e;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results.push_back(want);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(logic [VW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        modulus_now  = v;
    endtask

    function automatic logic [VW-1:0] pick_operand(logic [VW-1:0] modv);
        logic [63:0] near;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20);
            1:
            begin
                near = {32'd0, modv} + $urandom_range(0, 4) - 2;
                return near[VW-1:0];
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_random();
        cmd_t          c;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [EW-1:0] e;
        logic [63:0]   alias_b;
        c = cmd_t'($urandom_range(0, 7));
        a = pick_operand(modulus_now);
        b = pick_operand(modulus_now);
        if (c == CMD_EQU && $urandom_range(0, 1) == 1)
        begin
            alias_b = {32'd0, a} + (($urandom_range(0, 1) == 1) ? {32'd0, modulus_now} : 64'd0);
            b = (alias_b[63:32] == 0) ? alias_b[VW-1:0] : a;
        end
        if ($urandom_range(0, 7) == 0)
            e = EW'({$urandom, $urandom});
        else
            e = EW'($urandom_range(0, 300));
        offer(c, a, b, e, predict_result(c, a, b, e, modulus_now));
    endtask

    initial
    begin
        logic [VW-1:0] observed;
        logic [VW-1:0] want;
        int            gap;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            gap = gaps_on ? $urandom_range(0, 13) : 0;
            if (beats_out == 60 || beats_out == 110)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            observed = result;
            beats_out++;
            if (awaited_results.size() == 0)
                report($sformatf("result %0d arrived with nothing awaited", observed));
            else
            begin
                want = awaited_results.pop_front();
                if (observed !== want)
                    report($sformatf("beat %0d: expected %0d, got %0d", beats_out, want,
                                     observed));
            end
        end
    end

    initial
    begin
        logic [VW-1:0] phase_mod [PHASES];
        plan_row_t     row;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        command     <= CMD_ADD;
        operand_a   <= '0;
        operand_b   <= '0;
        exponent    <= '0;
        out_stall   <= 1'b1;
        cycles       = 0;
        mismatches   = 0;
        beats_out    = 0;
        gaps_on      = 1'b1;
        modulus_now  = MODULUS_RESET;

        plan = '{
            '{1'b0, CMD_ADD, 32'd0, 32'd0, 63'd0, 1'b1, 32'd0},
            '{1'b0, CMD_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_SUB, 32'd0, 32'd1, 63'd0, 1'b1, 32'd1000000006},
            '{1'b0, CMD_NEG, 32'd1, 32'hFFFFFFFF, {EW{1'b1}}, 1'b1, 32'd1000000006},
            '{1'b0, CMD_NEG, 32'd0, 32'd0, 63'd0, 1'b1, 32'd0},
            '{1'b0, CMD_MUL, 32'hFFFFFFFF, 32'hFFFFFFFF, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_DIV, 32'd5, 32'd1000000007, 63'd0, 1'b1, 32'd0},
            '{1'b0, CMD_POW, 32'd0, 32'd0, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_POW, 32'd2, 32'd0, 63'd10, 1'b1, 32'd1024},
            '{1'b0, CMD_POW, 32'hFFFFFFFF, 32'd0, {EW{1'b1}}, 1'b0, 32'd0},
            '{1'b0, CMD_INV, 32'd0, 32'd0, 63'd0, 1'b1, 32'd0},
            '{1'b0, CMD_INV, 32'd2, 32'd0, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_EQU, 32'd1000000008, 32'd1, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_EQU, 32'd3, 32'd4, 63'd0, 1'b1, 32'd0},
            '{1'b1, CMD_ADD, 32'd2, 32'd0, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_INV, 32'd1, 32'd0, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_INV, 32'd3, 32'd0, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_DIV, 32'hFFFFFFFF, 32'd1, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_SUB, 32'd0, 32'd1, 63'd0, 1'b1, 32'd1},
            '{1'b1, CMD_ADD, 32'hFFFFFFFF, 32'd0, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_ADD, 32'hFFFFFFFE, 32'hFFFFFFFE, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_MUL, 32'hFFFFFFFE, 32'hFFFFFFFE, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_NEG, 32'hFFFFFFFF, 32'd0, 63'd0, 1'b1, 32'd0},
            '{1'b0, CMD_EQU, 32'hFFFFFFFF, 32'd0, 63'd0, 1'b1, 32'd1},
            '{1'b0, CMD_SUB, 32'd0, 32'hFFFFFFFE, 63'd0, 1'b0, 32'd0},
            '{1'b1, CMD_ADD, PRIME_MAX, 32'd0, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_DIV, 32'hFFFFFFFF, 32'd2, 63'd0, 1'b0, 32'd0},
            '{1'b0, CMD_INV, 32'hFFFFFFFA, 32'd0, 63'd0, 1'b1, 32'hFFFFFFFA},
            '{1'b0, CMD_POW, 32'd3, 32'd0, 63'd300, 1'b0, 32'd0}
        };

        phase_mod[0] = MODULUS_RESET;
        phase_mod[1] = 32'd13;
        phase_mod[2] = PRIME_MAX;
        phase_mod[3] = 32'd2;
        phase_mod[4] = $urandom | 32'd2;
        phase_mod[5] = 32'd65537;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                settle();
                write_modulus(row.a);
            end
            else
                offer(row.cmd, row.a, row.b, row.e,
                      row.typed ? row.want
                                : predict_result(row.cmd, row.a, row.b, row.e, modulus_now));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_modulus(phase_mod[p]);
            gaps_on = (p % 2 == 0);
            repeat (PHASE_BEATS) offer_random();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
